### sv/chsp_pkg.sv
// shared types and constants of the cpio header stream parser
package chsp_pkg;

	localparam logic [3:0] PH_DETECT = 4'd0;
	localparam logic [3:0] PH_HEADER = 4'd1;
	localparam logic [3:0] PH_NAME   = 4'd2;
	localparam logic [3:0] PH_SKIP   = 4'd3;
	localparam logic [3:0] PH_DONE   = 4'd4;

	localparam logic [1:0] FMT_NEWC  = 2'd0;
	localparam logic [1:0] FMT_ODC   = 2'd1;
	localparam logic [1:0] FMT_BINLE = 2'd2;
	localparam logic [1:0] FMT_BINBE = 2'd3;

	localparam logic [1:0] KIND_NAME  = 2'd0;
	localparam logic [1:0] KIND_ENTRY = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	localparam logic [2:0] ERR_MAGIC   = 3'd0;
	localparam logic [2:0] ERR_HMAGIC  = 3'd1;
	localparam logic [2:0] ERR_NUMBER  = 3'd2;
	localparam logic [2:0] ERR_ZNAME   = 3'd3;
	localparam logic [2:0] ERR_EARLY   = 3'd4;
	localparam logic [2:0] ERR_OFFSET  = 3'd5;

	localparam logic [1:0] TGT_MODE = 2'd0;
	localparam logic [1:0] TGT_NSZ  = 2'd1;
	localparam logic [1:0] TGT_FSZ  = 2'd2;

	localparam logic [47:0] MAGIC_N1  = 48'h303730373031;
	localparam logic [47:0] MAGIC_N2  = 48'h303730373032;
	localparam logic [47:0] MAGIC_ODC = 48'h303730373037;
	localparam logic [15:0] MAGIC_BLE = 16'hC771;
	localparam logic [15:0] MAGIC_BBE = 16'h71C7;

	typedef struct packed {
		logic [7:0] arch_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  name_byte;
		logic [47:0] data_start;
		logic [31:0] file_size;
		logic [31:0] mode;
		logic [2:0]  error_code;
	} out_item_t;

	// field slot: start, length, target
	typedef struct packed {
		logic [6:0] start;
		logic [3:0] len;
		logic [1:0] target;
	} slot_t;

	function automatic slot_t slot_of(input logic [1:0] fmt, input logic [1:0] i);
		slot_t s;
		s = '{7'd6, 4'd2, TGT_MODE};
		unique case (fmt)
			FMT_NEWC: begin
				unique case (i)
					2'd0: s = '{7'd14, 4'd8, TGT_MODE};
					2'd1: s = '{7'd54, 4'd8, TGT_FSZ};
					default: s = '{7'd94, 4'd8, TGT_NSZ};
				endcase
			end
			FMT_ODC: begin
				unique case (i)
					2'd0: s = '{7'd18, 4'd6, TGT_MODE};
					2'd1: s = '{7'd59, 4'd6, TGT_NSZ};
					default: s = '{7'd65, 4'd11, TGT_FSZ};
				endcase
			end
			default: begin
				unique case (i)
					2'd0: s = '{7'd6, 4'd2, TGT_MODE};
					2'd1: s = '{7'd20, 4'd2, TGT_NSZ};
					default: s = '{7'd22, 4'd4, TGT_FSZ};
				endcase
			end
		endcase
		return s;
	endfunction

	function automatic logic [6:0] header_len(input logic [1:0] fmt);
		unique case (fmt)
			FMT_NEWC: return 7'd110;
			FMT_ODC:  return 7'd76;
			default:  return 7'd26;
		endcase
	endfunction

	function automatic logic [7:0] trailer_char(input logic [3:0] i);
		unique case (i)
			4'd0: return 8'h54;
			4'd1: return 8'h52;
			4'd2: return 8'h41;
			4'd3: return 8'h49;
			4'd4: return 8'h4C;
			4'd5: return 8'h45;
			4'd6: return 8'h52;
			default: return 8'h21;
		endcase
	endfunction

endpackage

### sv/chsp_if.sv
// valid/ready channel with a typed payload
interface chsp_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/cpio_header_stream_parser_top.sv
// cpio header stream parser: one archive byte in, at most one result out
// usage:
//   in_ch carries archive bytes with a last flag; out_ch carries results
//   (name byte, entry record, archive end or error).
//   each byte is parsed in the cycle it is taken, by logic between the
//   parser state registers and the result register, so one byte is
//   accepted per cycle while results are taken; a result shows in the cycle after its byte.
//   throughput: one byte per cycle while the receiver takes results.
//   the result register frees in the same cycle it is read, so in_ch
//   stays ready while out_ch is empty or being read; when the receiver
//   stalls with a result held, in_ch ready drops until it is taken.
//   a byte that causes no result still needs the result slot free.
//   at reset all parser state returns to format detection and the result
//   register is empty.
//   after an end or error bytes are dropped until the last flag, which
//   restarts the parser from offset zero.
//   OFFSET_BITS sets the width of the archive byte counter.
module cpio_header_stream_parser_top #(
	parameter int OFFSET_BITS = 48
) (
	input logic clk,
	input logic arst_n,
	chsp_if.sink in_ch,
	chsp_if.source out_ch
);

	localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

	logic [3:0]  phase_q;
	logic [1:0]  fmt_q;
	logic [6:0]  hpos_q;
	logic [OFFSET_BITS-1:0] bpos_q;
	logic [47:0] magic_q;
	logic [33:0] acc_q;
	logic        stop_q, seen_q;
	logic [31:0] emode_q, nlen_q, esize_q, nrem_q;
	logic [32:0] skip_q;
	logic        tmatch_q, nfault_q, full_q;

	logic        ovalid_q;
	chsp_pkg::out_item_t odata_q;

	logic accept;
	assign in_ch.ready = !ovalid_q || out_ch.ready;
	assign accept = in_ch.valid && in_ch.ready;
	assign out_ch.valid = ovalid_q;
	assign out_ch.data = odata_q;

	// next state and result of one byte
	logic [3:0]  phase_d;
	logic [1:0]  fmt_d;
	logic [6:0]  hpos_d;
	logic [OFFSET_BITS-1:0] bpos_d;
	logic [47:0] magic_d;
	logic [33:0] acc_d;
	logic        stop_d, seen_d;
	logic [31:0] emode_d, nlen_d, esize_d, nrem_d;
	logic [32:0] skip_d;
	logic        tmatch_d, nfault_d, full_d;
	logic        emit;
	chsp_pkg::out_item_t res;

	always_comb begin
		logic [7:0] b;
		logic [15:0] top;
		logic ok;
		chsp_pkg::slot_t s;
		logic [6:0] k;
		logic [33:0] mul;
		logic [4:0] dg;
		logic dv;
		logic [4:0] sh;
		logic [1:0] amask;
		logic [OFFSET_BITS:0] d, pad1, dat;
		logic [1:0] pad2;
		logic [31:0] idx;
		b = in_ch.data.arch_byte;
		phase_d = phase_q; fmt_d = fmt_q; hpos_d = hpos_q; bpos_d = bpos_q;
		magic_d = magic_q; acc_d = acc_q; stop_d = stop_q; seen_d = seen_q;
		emode_d = emode_q; nlen_d = nlen_q; esize_d = esize_q; nrem_d = nrem_q;
		skip_d = skip_q; tmatch_d = tmatch_q; nfault_d = nfault_q; full_d = full_q;
		emit = 1'b0;
		res = '0;
		top = '0; ok = 1'b0; s = '0; k = '0; mul = '0; dg = '0; dv = 1'b0;
		sh = '0; amask = '0; d = '0; pad1 = '0; dat = '0; pad2 = '0; idx = '0;
		if (phase_q != chsp_pkg::PH_DONE) begin
			if (full_q) begin
				emit = 1'b1;
				res.kind = chsp_pkg::KIND_ERROR;
				res.error_code = chsp_pkg::ERR_OFFSET;
				phase_d = chsp_pkg::PH_DONE;
			end else begin
				priority if (phase_q == chsp_pkg::PH_DETECT ||
						phase_q == chsp_pkg::PH_HEADER) begin
					if (hpos_q < 7'd6) magic_d = {magic_q[39:0], b};
					top = magic_d[47:32];
					if (phase_q == chsp_pkg::PH_DETECT) begin
						if (hpos_q < 7'd5) begin
							hpos_d = hpos_q + 7'd1;
						end else begin
							phase_d = chsp_pkg::PH_HEADER;
							hpos_d = 7'd6;
							priority if (top == chsp_pkg::MAGIC_BLE)
								fmt_d = chsp_pkg::FMT_BINLE;
							else if (top == chsp_pkg::MAGIC_BBE)
								fmt_d = chsp_pkg::FMT_BINBE;
							else if (magic_d == chsp_pkg::MAGIC_N1 ||
									magic_d == chsp_pkg::MAGIC_N2)
								fmt_d = chsp_pkg::FMT_NEWC;
							else if (magic_d == chsp_pkg::MAGIC_ODC)
								fmt_d = chsp_pkg::FMT_ODC;
							else begin
								emit = 1'b1;
								res.kind = chsp_pkg::KIND_ERROR;
								res.error_code = chsp_pkg::ERR_MAGIC;
								phase_d = chsp_pkg::PH_DONE;
								hpos_d = hpos_q;
							end
						end
					end else begin
						if (hpos_q == 7'd0) nfault_d = 1'b0;
						// field slots are disjoint, at most one matches
						for (int i = 0; i < 3; i++) begin
							s = chsp_pkg::slot_of(fmt_q, 2'(i));
							if (hpos_q >= s.start && hpos_q < s.start + 7'(s.len)) begin
								k = hpos_q - s.start;
								if (k == 7'd0) begin
									acc_d = '0; stop_d = 1'b0; seen_d = 1'b0;
								end
								if (fmt_q == chsp_pkg::FMT_BINLE) begin
									sh = {k[0], 3'b000} +
										((s.len == 4'd4 && k < 7'd2) ? 5'd16 : 5'd0);
									acc_d = acc_d | (34'(b) << sh);
								end else if (fmt_q == chsp_pkg::FMT_BINBE) begin
									acc_d = {acc_d[25:0], b};
								end else if (!stop_d) begin
									dv = 1'b1;
									priority if (b >= 8'h30 && b <= 8'h39) dg = 5'(b - 8'h30);
									else if (b >= 8'h61 && b <= 8'h66) dg = 5'(b - 8'h57);
									else if (b >= 8'h41 && b <= 8'h46) dg = 5'(b - 8'h37);
									else dv = 1'b0;
									if (fmt_q == chsp_pkg::FMT_ODC && dg > 5'd7) dv = 1'b0;
									if (!dv) stop_d = 1'b1;
									else begin
										mul = (fmt_q == chsp_pkg::FMT_NEWC) ?
											{acc_d[29:0], 4'b0} : {acc_d[30:0], 3'b0};
										acc_d = mul + 34'(dg);
										seen_d = 1'b1;
									end
								end
								if (k + 7'd1 == 7'(s.len)) begin
									if (fmt_q < chsp_pkg::FMT_BINLE &&
											(!seen_d || acc_d[33:32] != 2'b00))
										nfault_d = 1'b1;
									unique case (s.target)
										chsp_pkg::TGT_MODE: emode_d = acc_d[31:0];
										chsp_pkg::TGT_NSZ:  nlen_d = acc_d[31:0];
										default:            esize_d = acc_d[31:0];
									endcase
								end
							end
						end
						if (hpos_q + 7'd1 < chsp_pkg::header_len(fmt_q)) begin
							hpos_d = hpos_q + 7'd1;
						end else begin
							unique case (fmt_q)
								chsp_pkg::FMT_NEWC: ok = magic_d == chsp_pkg::MAGIC_N1 ||
									magic_d == chsp_pkg::MAGIC_N2;
								chsp_pkg::FMT_ODC: ok = magic_d == chsp_pkg::MAGIC_ODC;
								chsp_pkg::FMT_BINLE: ok = top == chsp_pkg::MAGIC_BLE;
								default: ok = top == chsp_pkg::MAGIC_BBE;
							endcase
							res.kind = chsp_pkg::KIND_ERROR;
							priority if (!ok) begin
								emit = 1'b1; res.error_code = chsp_pkg::ERR_HMAGIC;
								phase_d = chsp_pkg::PH_DONE;
							end else if (nfault_d) begin
								emit = 1'b1; res.error_code = chsp_pkg::ERR_NUMBER;
								phase_d = chsp_pkg::PH_DONE;
							end else if (nlen_d == 32'd0) begin
								emit = 1'b1; res.error_code = chsp_pkg::ERR_ZNAME;
								phase_d = chsp_pkg::PH_DONE;
							end else begin
								nrem_d = nlen_d; tmatch_d = 1'b1;
								phase_d = chsp_pkg::PH_NAME;
							end
						end
					end
				end else if (phase_q == chsp_pkg::PH_NAME) begin
					emit = 1'b1;
					if (nrem_q > 32'd1) begin
						idx = nlen_q - nrem_q;
						if (idx >= 32'd10 || b != chsp_pkg::trailer_char(idx[3:0]))
							tmatch_d = 1'b0;
						nrem_d = nrem_q - 32'd1;
						res.kind = chsp_pkg::KIND_NAME;
						res.name_byte = b;
					end else if (tmatch_q && nlen_q == 32'd11) begin
						phase_d = chsp_pkg::PH_DONE;
						res.kind = chsp_pkg::KIND_END;
					end else begin
						unique case (fmt_q)
							chsp_pkg::FMT_NEWC: amask = 2'd3;
							chsp_pkg::FMT_ODC:  amask = 2'd0;
							default:            amask = 2'd1;
						endcase
						d = {1'b0, bpos_q} + 1'b1;
						pad1 = (OFFSET_BITS+1)'((~d[1:0] + 2'd1) & amask);
						dat = d + pad1;
						pad2 = (~(dat[1:0] + esize_q[1:0]) + 2'd1) & amask;
						if (bpos_q == OFF_MAX || dat[OFFSET_BITS]) begin
							res.kind = chsp_pkg::KIND_ERROR;
							res.error_code = chsp_pkg::ERR_OFFSET;
							phase_d = chsp_pkg::PH_DONE;
						end else begin
							skip_d = 33'(pad1[1:0]) + 33'(esize_q) + 33'(pad2);
							if (skip_d == 33'd0) begin
								phase_d = chsp_pkg::PH_HEADER; hpos_d = 7'd0;
							end else phase_d = chsp_pkg::PH_SKIP;
							res.kind = chsp_pkg::KIND_ENTRY;
							res.data_start = 48'(dat[OFFSET_BITS-1:0]);
							res.file_size = esize_q;
							res.mode = emode_q;
						end
					end
				end else begin
					skip_d = skip_q - 33'd1;
					if (skip_d == 33'd0) begin
						phase_d = chsp_pkg::PH_HEADER; hpos_d = 7'd0;
					end
				end
				if (bpos_q == OFF_MAX) full_d = 1'b1;
				else bpos_d = bpos_q + 1'b1;
			end
		end
		if (in_ch.data.last_byte) begin
			if (phase_d != chsp_pkg::PH_DONE) begin
				emit = 1'b1;
				res = '0;
				res.kind = chsp_pkg::KIND_ERROR;
				res.error_code = chsp_pkg::ERR_EARLY;
			end
			phase_d = chsp_pkg::PH_DETECT; fmt_d = '0; hpos_d = '0; bpos_d = '0;
			magic_d = '0; acc_d = '0; stop_d = 1'b0; seen_d = 1'b0;
			emode_d = '0; nlen_d = '0; esize_d = '0; nrem_d = '0; skip_d = '0;
			tmatch_d = 1'b1; nfault_d = 1'b0; full_d = 1'b0;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= chsp_pkg::PH_DETECT; fmt_q <= '0; hpos_q <= '0; bpos_q <= '0;
			magic_q <= '0; acc_q <= '0; stop_q <= 1'b0; seen_q <= 1'b0;
			emode_q <= '0; nlen_q <= '0; esize_q <= '0; nrem_q <= '0; skip_q <= '0;
			tmatch_q <= 1'b1; nfault_q <= 1'b0; full_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d; fmt_q <= fmt_d; hpos_q <= hpos_d; bpos_q <= bpos_d;
			magic_q <= magic_d; acc_q <= acc_d; stop_q <= stop_d; seen_q <= seen_d;
			emode_q <= emode_d; nlen_q <= nlen_d; esize_q <= esize_d; nrem_q <= nrem_d;
			skip_q <= skip_d; tmatch_q <= tmatch_d; nfault_q <= nfault_d;
			full_q <= full_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (accept) begin
			ovalid_q <= emit;
		end else if (out_ch.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) odata_q <= res;
	end

endmodule
